FILE: src/wsp_pkg.sv
// Shared constants for the world-to-screen projection pipeline.
`default_nettype none
package wsp_pkg;
  // exact clip sum width: four 64-bit signed terms
  localparam int SUM_W = 66;
  // quotient bits developed by the divider; values at or above 2^35 flag overflow
  localparam int QUO_W = 35;
  // ratio clamp, 2^33
  localparam logic [QUO_W-1:0] QUO_CLAMP = QUO_W'(64'h2_0000_0000);
  // configuration register indexes
  localparam logic [2:0] REG_ROW0_A = 3'd0;
  localparam logic [2:0] REG_ROW0_B = 3'd1;
  localparam logic [2:0] REG_ROW1_A = 3'd2;
  localparam logic [2:0] REG_ROW1_B = 3'd3;
  localparam logic [2:0] REG_ROW2_A = 3'd4;
  localparam logic [2:0] REG_ROW2_B = 3'd5;
  localparam logic [2:0] REG_ROW3_A = 3'd6;
  localparam logic [2:0] REG_ROW3_B = 3'd7;
endpackage
`default_nettype wire

FILE: src/wsp_div_step.sv
// One restoring-division step: shift in a numerator bit, compare, subtract.
`default_nettype none
module wsp_div_step (
  input  wire logic [wsp_pkg::SUM_W-1:0] rem,
  input  wire logic                      num_bit,
  input  wire logic [wsp_pkg::SUM_W-1:0] divisor,
  output logic      [wsp_pkg::SUM_W-1:0] rem_out,
  output logic                           quo_bit
);
  logic [wsp_pkg::SUM_W:0] trial;
  logic [wsp_pkg::SUM_W:0] diff;

  always_comb begin
    trial   = {rem, num_bit};
    diff    = trial - {1'b0, divisor};
    quo_bit = (trial >= {1'b0, divisor});
    rem_out = quo_bit ? diff[wsp_pkg::SUM_W-1:0] : trial[wsp_pkg::SUM_W-1:0];
  end
endmodule
`default_nettype wire

FILE: src/world_to_screen_projection_core.sv
// World-to-screen projection core: 4x4 matrix transform and perspective divide.
//
// Input channel (in_valid/in_ready) carries one world point world_x/y/z in
// signed Q16.16. Output channel (out_valid/out_ready) returns one result per
// point: in_front and the relative screen position rel_x/rel_y (Q16.16,
// saturated, zero when the point is at or behind the epsilon plane).
// The matrix is loaded through cfg_wr_en/cfg_index/cfg_data, one 64-bit
// register (two matrix entries) per write; load it only while the pipe is empty.
// Stages in order: 9 products, row sums, sign/magnitude, overflow check, 35
// divider stages (one quotient bit each, x and y in parallel) and the final
// offset/saturate stage. Throughput is one point per cycle when not stalled.
// The whole pipe advances together; when the receiver holds out_ready low
// with a result waiting, in_ready drops and every stage holds its contents.
// Reset empties the pipe and loads the identity matrix.
`default_nettype none
module world_to_screen_projection_core #(
  parameter int FRAC_BITS = 16,
  parameter int W_EPSILON = 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] world_x,
  input  wire logic signed [31:0] world_y,
  input  wire logic signed [31:0] world_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    in_front,
  output logic signed [31:0]      rel_x,
  output logic signed [31:0]      rel_y,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  localparam int SW = wsp_pkg::SUM_W;
  localparam int QB = wsp_pkg::QUO_W;
  localparam int NW = SW + FRAC_BITS - 1;
  localparam logic signed [SW-1:0] EPS = SW'(W_EPSILON) <<< FRAC_BITS;
  localparam logic signed [QB+1:0] HALF = (QB+2)'(1) <<< (FRAC_BITS - 1);
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = 64'(1) << (32 + FRAC_BITS);

  logic [63:0] mat [0:7];
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= ONE_LO;
      mat[1] <= '0;
      mat[2] <= ONE_HI;
      mat[3] <= '0;
      mat[4] <= '0;
      mat[5] <= ONE_LO;
      mat[6] <= '0;
      mat[7] <= ONE_HI;
    end else if (cfg_wr_en) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  // stage 1: products
  logic v1;
  logic signed [63:0] px [0:2];
  logic signed [63:0] py [0:2];
  logic signed [63:0] pw [0:2];
  logic signed [31:0] ax0, ax1, ax2, ay0, ay1, ay2, aw0, aw1, aw2;
  assign ax0 = mat[wsp_pkg::REG_ROW0_A][31:0];
  assign ax1 = mat[wsp_pkg::REG_ROW0_A][63:32];
  assign ax2 = mat[wsp_pkg::REG_ROW0_B][31:0];
  assign ay0 = mat[wsp_pkg::REG_ROW1_A][31:0];
  assign ay1 = mat[wsp_pkg::REG_ROW1_A][63:32];
  assign ay2 = mat[wsp_pkg::REG_ROW1_B][31:0];
  assign aw0 = mat[wsp_pkg::REG_ROW3_A][31:0];
  assign aw1 = mat[wsp_pkg::REG_ROW3_A][63:32];
  assign aw2 = mat[wsp_pkg::REG_ROW3_B][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= ax0 * world_x;
      px[1] <= ax1 * world_y;
      px[2] <= ax2 * world_z;
      py[0] <= ay0 * world_x;
      py[1] <= ay1 * world_y;
      py[2] <= ay2 * world_z;
      pw[0] <= aw0 * world_x;
      pw[1] <= aw1 * world_y;
      pw[2] <= aw2 * world_z;
    end
  end

  // stage 2: row sums, translation column scaled by one
  logic v2;
  logic signed [SW-1:0] cx, cy, cw;
  logic signed [31:0] tx, ty, tw;
  assign tx = mat[wsp_pkg::REG_ROW0_B][63:32];
  assign ty = mat[wsp_pkg::REG_ROW1_B][63:32];
  assign tw = mat[wsp_pkg::REG_ROW3_B][63:32];

  always_ff @(posedge clk) begin
    if (en) begin
      cx <= SW'(px[0]) + SW'(px[1]) + SW'(px[2]) + (SW'(tx) <<< FRAC_BITS);
      cy <= SW'(py[0]) + SW'(py[1]) + SW'(py[2]) + (SW'(ty) <<< FRAC_BITS);
      cw <= SW'(pw[0]) + SW'(pw[1]) + SW'(pw[2]) + (SW'(tw) <<< FRAC_BITS);
    end
  end

  // stage 3: sign/magnitude and plane test
  logic v3, front3, negx3, negy3;
  logic [SW-1:0] magx3, magy3, w3;
  always_ff @(posedge clk) begin
    if (en) begin
      front3 <= (cw > EPS);
      negx3  <= cx[SW-1];
      negy3  <= cy[SW-1];
      magx3  <= cx[SW-1] ? SW'(-cx) : SW'(cx);
      magy3  <= cy[SW-1] ? SW'(-cy) : SW'(cy);
      w3     <= SW'(cw);
    end
  end

  // stage 4: numerator = mag * 2^(F-1); quotient overflow if top part >= w
  logic [NW-1:0] numx, numy;
  assign numx = {magx3, {(FRAC_BITS-1){1'b0}}};
  assign numy = {magy3, {(FRAC_BITS-1){1'b0}}};

  logic [SW-1:0] rem_x [0:QB];
  logic [SW-1:0] rem_y [0:QB];
  logic [QB-1:0] low_x [0:QB];
  logic [QB-1:0] low_y [0:QB];
  logic [QB-1:0] quo_x [0:QB];
  logic [QB-1:0] quo_y [0:QB];
  logic [SW-1:0] dw    [0:QB];
  logic          ovf_x [0:QB];
  logic          ovf_y [0:QB];
  logic          neg_x [0:QB];
  logic          neg_y [0:QB];
  logic          front [0:QB];
  logic [QB:0]   dv;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x[0] <= SW'(numx[NW-1:QB]);
      rem_y[0] <= SW'(numy[NW-1:QB]);
      ovf_x[0] <= (SW'(numx[NW-1:QB]) >= w3);
      ovf_y[0] <= (SW'(numy[NW-1:QB]) >= w3);
      low_x[0] <= numx[QB-1:0];
      low_y[0] <= numy[QB-1:0];
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      dw[0]    <= w3;
      neg_x[0] <= negx3;
      neg_y[0] <= negy3;
      front[0] <= front3;
    end
  end

  // divider stages, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [SW-1:0] rx, ry;
    logic          bx, by;

    wsp_div_step u_step_x (
      .rem(rem_x[k]), .num_bit(low_x[k][QB-1]), .divisor(dw[k]),
      .rem_out(rx), .quo_bit(bx)
    );
    wsp_div_step u_step_y (
      .rem(rem_y[k]), .num_bit(low_y[k][QB-1]), .divisor(dw[k]),
      .rem_out(ry), .quo_bit(by)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[k+1] <= rx;
        rem_y[k+1] <= ry;
        low_x[k+1] <= {low_x[k][QB-2:0], 1'b0};
        low_y[k+1] <= {low_y[k][QB-2:0], 1'b0};
        quo_x[k+1] <= {quo_x[k][QB-2:0], bx};
        quo_y[k+1] <= {quo_y[k][QB-2:0], by};
        dw[k+1]    <= dw[k];
        ovf_x[k+1] <= ovf_x[k];
        ovf_y[k+1] <= ovf_y[k];
        neg_x[k+1] <= neg_x[k];
        neg_y[k+1] <= neg_y[k];
        front[k+1] <= front[k];
      end
    end
  end

  // final stage: clamp, sign, offset by one half, saturate
  logic [QB-1:0]   qcx, qcy;
  logic signed [QB+1:0] vx, vy;
  logic signed [31:0] satx, saty;

  always_comb begin
    qcx = (ovf_x[QB] || quo_x[QB] > wsp_pkg::QUO_CLAMP) ? wsp_pkg::QUO_CLAMP : quo_x[QB];
    qcy = (ovf_y[QB] || quo_y[QB] > wsp_pkg::QUO_CLAMP) ? wsp_pkg::QUO_CLAMP : quo_y[QB];
    // x adds the ratio, y subtracts it
    vx = neg_x[QB]  ? HALF - $signed({2'b00, qcx}) : HALF + $signed({2'b00, qcx});
    vy = !neg_y[QB] ? HALF - $signed({2'b00, qcy}) : HALF + $signed({2'b00, qcy});
    if (vx > (QB+2)'(64'sh7FFF_FFFF))       satx = 32'sh7FFF_FFFF;
    else if (vx < -(QB+2)'(64'sh8000_0000)) satx = 32'sh8000_0000;
    else                                    satx = vx[31:0];
    if (vy > (QB+2)'(64'sh7FFF_FFFF))       saty = 32'sh7FFF_FFFF;
    else if (vy < -(QB+2)'(64'sh8000_0000)) saty = 32'sh8000_0000;
    else                                    saty = vy[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_front <= front[QB];
      rel_x    <= front[QB] ? satx : '0;
      rel_y    <= front[QB] ? saty : '0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      dv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      dv        <= {dv[QB-1:0], v3};
      out_valid <= dv[QB];
    end
  end

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_front |-> rel_x == 32'sd0 && rel_y == 32'sd0)
    else $error("result behind plane is not zero");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipe stalled without a waiting result");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && dv == '0)
    else $error("pipe not empty after reset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && !out_ready) && !$past(rst) |-> $stable(dv) && out_valid)
    else $error("pipe moved during stall");
endmodule
`default_nettype wire
